// ===== design/ubx_pkg.sv =====
package ubx_pkg;

    localparam int DEF_PAYLOAD_DEPTH = 64;
    localparam int SLOT_COUNT        = 4;
    localparam int ADDR_W            = 5;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [2:0] REG_CLASS = 3'd0;
    localparam logic [2:0] REG_SLOT0 = 3'd1;
    localparam logic [2:0] REG_SLOT1 = 3'd2;
    localparam logic [2:0] REG_SLOT2 = 3'd3;
    localparam logic [2:0] REG_SLOT3 = 3'd4;

    localparam logic [7:0]  RST_CLASS = 8'h01;
    localparam logic [23:0] RST_SLOT0 = 24'h02001C;
    localparam logic [23:0] RST_SLOT1 = 24'h030010;
    localparam logic [23:0] RST_SLOT2 = 24'h060034;
    localparam logic [23:0] RST_SLOT3 = 24'h120024;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CHECK_A = 4'd7,
        PH_CHECK_B = 4'd8
    } phase_t;

    typedef struct packed {
        logic [7:0]                        wanted_class;
        logic [SLOT_COUNT-1:0][23:0]       slots;
    } cfg_t;

    typedef struct packed {
        logic        go;
        logic [15:0] len;
        logic [1:0]  slot;
    } emit_req_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } emit_stat_t;

endpackage

// ===== design/ubx_frame_receiver.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   rx_byte
// output    out        out_valid/out_stall payload_byte, message_slot, last_byte
// config    in         APB psel/penable    paddr, pwdata, prdata
//
// One received byte is taken per cycle while a frame is parsed, unless in_stall holds it.
// After a good check byte the stored payload streams out one byte at a time,
// paced by the payload RAM read and the single output register and held by out_stall.
// Input stalls while the payload streams; reset returns to preamble hunt.
// Payload RAM contents are not cleared at reset.
module ubx_frame_receiver
    import ubx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        payload_byte,
    output logic [1:0]        message_slot,
    output logic              last_byte,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    cfg_t          cfg;
    emit_req_t     req;
    emit_stat_t    stat;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    ubx_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ubx_parser #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .cfg      (cfg),
        .stat     (stat),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .req      (req)
    );

    ubx_payload_ram #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ubx_emitter #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .stat         (stat),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .message_slot (message_slot),
        .last_byte    (last_byte)
    );

endmodule

// ===== design/ubx_regs.sv =====
module ubx_regs
    import ubx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [7:0]  class_reg;
    logic [23:0] slot0_reg;
    logic [23:0] slot1_reg;
    logic [23:0] slot2_reg;
    logic [23:0] slot3_reg;
    logic [2:0]  index;
    logic        wr;

    assign index  = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= RST_CLASS;
            slot0_reg <= RST_SLOT0;
            slot1_reg <= RST_SLOT1;
            slot2_reg <= RST_SLOT2;
            slot3_reg <= RST_SLOT3;
        end
        else if (wr)
        begin
            unique case (index)
                REG_CLASS: class_reg <= pwdata[7:0];
                REG_SLOT0: slot0_reg <= pwdata[23:0];
                REG_SLOT1: slot1_reg <= pwdata[23:0];
                REG_SLOT2: slot2_reg <= pwdata[23:0];
                REG_SLOT3: slot3_reg <= pwdata[23:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_CLASS: prdata = {24'd0, class_reg};
            REG_SLOT0: prdata = {8'd0, slot0_reg};
            REG_SLOT1: prdata = {8'd0, slot1_reg};
            REG_SLOT2: prdata = {8'd0, slot2_reg};
            REG_SLOT3: prdata = {8'd0, slot3_reg};
            default:   prdata = 32'd0;
        endcase
    end

    assign cfg.wanted_class = class_reg;
    assign cfg.slots[0]     = slot0_reg;
    assign cfg.slots[1]     = slot1_reg;
    assign cfg.slots[2]     = slot2_reg;
    assign cfg.slots[3]     = slot3_reg;

endmodule

// ===== design/ubx_payload_ram.sv =====
module ubx_payload_ram
    import ubx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [PAYLOAD_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/ubx_parser.sv =====
module ubx_parser
    import ubx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  cfg_t          cfg,
    input  emit_stat_t    stat,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data,
    output emit_req_t     req
);

    phase_t      phase_reg, phase_next;
    logic        gathering_reg, gathering_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [1:0]  slot_reg, slot_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;
    logic        accept;
    logic [7:0]  add_a;
    logic [7:0]  add_b;
    logic [15:0] len_full;
    logic [15:0] count_inc;

    assign in_stall  = stat.busy || (stat.out_full && phase_reg == PH_CHECK_B);
    assign accept    = in_valid && !in_stall;
    assign add_a     = sum_a_reg + rx_byte;
    assign add_b     = sum_b_reg + add_a;
    assign len_full  = {rx_byte, len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;

    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC1;
            gathering_reg <= 1'b0;
            sum_a_reg     <= 8'd0;
            sum_b_reg     <= 8'd0;
            slot_reg      <= 2'd0;
            len_reg       <= 16'd0;
            count_reg     <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            gathering_reg <= gathering_next;
            sum_a_reg     <= sum_a_next;
            sum_b_reg     <= sum_b_next;
            slot_reg      <= slot_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        gathering_next = gathering_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        slot_next      = slot_reg;
        len_next       = len_reg;
        count_next     = count_reg;
        wr_en          = 1'b0;
        req.go         = 1'b0;
        req.len        = len_reg;
        req.slot       = slot_reg;
        if (accept)
        begin
            unique case (phase_reg)
                PH_SYNC2:
                begin
                    if (rx_byte == SYNC_SECOND)
                    begin
                        phase_next = PH_CLASS;
                    end
                    else if (rx_byte == SYNC_FIRST)
                    begin
                        phase_next = PH_SYNC2;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CLASS:
                begin
                    phase_next     = PH_ID;
                    gathering_next = (rx_byte == cfg.wanted_class);
                    sum_a_next     = rx_byte;
                    sum_b_next     = rx_byte;
                end
                PH_ID:
                begin
                    phase_next = PH_LEN_LO;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    if (gathering_reg)
                    begin
                        priority if (cfg.slots[0][23:16] == rx_byte)
                        begin
                            slot_next = 2'd0;
                        end
                        else if (cfg.slots[1][23:16] == rx_byte)
                        begin
                            slot_next = 2'd1;
                        end
                        else if (cfg.slots[2][23:16] == rx_byte)
                        begin
                            slot_next = 2'd2;
                        end
                        else if (cfg.slots[3][23:16] == rx_byte)
                        begin
                            slot_next = 2'd3;
                        end
                        else
                        begin
                            gathering_next = 1'b0;
                        end
                    end
                end
                PH_LEN_LO:
                begin
                    phase_next = PH_LEN_HI;
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    len_next   = {8'd0, rx_byte};
                end
                PH_LEN_HI:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    len_next   = len_full;
                    count_next = 16'd0;
                    if (len_full != cfg.slots[slot_reg][15:0]
                        || len_full > 16'(PAYLOAD_DEPTH))
                    begin
                        gathering_next = 1'b0;
                    end
                    phase_next = (len_full == 16'd0) ? PH_CHECK_A : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    wr_en      = gathering_reg && (count_reg < 16'(PAYLOAD_DEPTH));
                    count_next = count_inc;
                    if (count_inc == len_reg)
                    begin
                        phase_next = PH_CHECK_A;
                    end
                end
                PH_CHECK_A:
                begin
                    phase_next = (rx_byte == sum_a_reg) ? PH_CHECK_B : PH_SYNC1;
                end
                PH_CHECK_B:
                begin
                    phase_next = PH_SYNC1;
                    req.go     = gathering_reg && (rx_byte == sum_b_reg);
                end
                default:
                begin
                    phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
                end
            endcase
        end
    end

endmodule

// ===== design/ubx_emitter.sv =====
module ubx_emitter
    import ubx_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = DEF_PAYLOAD_DEPTH,
    localparam int AW = $clog2(PAYLOAD_DEPTH),
    localparam int CW = $clog2(PAYLOAD_DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  emit_req_t     req,
    output emit_stat_t    stat,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  logic [7:0]    rd_data,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    payload_byte,
    output logic [1:0]    message_slot,
    output logic          last_byte
);

    logic          active_reg, active_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] len_reg, len_next;
    logic [1:0]    slot_reg, slot_next;
    logic          pending_reg, pending_next;
    logic          valid_reg, valid_next;
    logic          last_reg, last_next;
    logic          issue;
    logic [CW-1:0] cnt_inc;

    assign issue   = active_reg && !pending_reg && (!valid_reg || !out_stall);
    assign cnt_inc = cnt_reg + CW'(1);
    assign rd_en   = issue;
    assign rd_addr = cnt_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            cnt_reg     <= '0;
            len_reg     <= '0;
            slot_reg    <= 2'd0;
            pending_reg <= 1'b0;
            valid_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            slot_reg    <= slot_next;
            pending_reg <= pending_next;
            valid_reg   <= valid_next;
            last_reg    <= last_next;
        end
    end

    always_comb
    begin
        active_next  = active_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        slot_next    = slot_reg;
        last_next    = last_reg;
        pending_next = issue;
        valid_next   = pending_reg || (valid_reg && out_stall);
        if (req.go)
        begin
            active_next = (req.len[CW-1:0] != '0);
            cnt_next    = '0;
            len_next    = req.len[CW-1:0];
            slot_next   = req.slot;
        end
        else if (issue)
        begin
            cnt_next  = cnt_inc;
            last_next = (cnt_inc == len_reg);
            if (cnt_inc == len_reg)
            begin
                active_next = 1'b0;
            end
        end
    end

    assign stat.busy     = active_reg || pending_reg;
    assign stat.out_full = valid_reg;

    assign out_valid    = valid_reg;
    assign payload_byte = rd_data;
    assign message_slot = slot_reg;
    assign last_byte    = last_reg;

endmodule
